>>> src/hctg_pkg.sv
// hctg_pkg: shared constants, types and command/status bundles of the hop table generator
// no dependencies; compiled first
`timescale 1ns / 1ps

package hctg_pkg;

    // table length and index widths
    localparam int NUM_CHANNELS = 16;
    localparam int SLOT_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MAX_OUT      = 16;

    // field widths
    localparam int SEED_W       = 32;
    localparam int ADDR_W       = 8;
    localparam int SLOT_OUT_W   = 4;
    localparam int CHAN_W       = 8;

    // generator and channel constants
    localparam logic [SEED_W-1:0] LCG_MUL    = 32'h0019_660D;
    localparam logic [SEED_W-1:0] LCG_ADD    = 32'h3C6E_F35F;
    localparam int                BAND_WIDTH = 41;
    localparam int                MIN_GAP    = 5;

    // remainder unit: one byte of the shifted state per step
    localparam int REM_W       = $clog2(BAND_WIDTH);
    localparam int MOD_DIGIT_W = 8;
    localparam int MOD_STEPS   = SEED_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CHAN_W-1:0] t_chan;

    typedef struct packed {
        logic load_seed;
        logic lcg_step;
        logic mod_load;
        logic mod_step;
        logic cand_load;
        logic probe_inc;
        logic entry_write;
        logic out_load;
        logic slot_next;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_done;
        logic slot_zero;
        logic slot_last;
        logic slot_out;
        logic probe_last;
        logic close;
        logic out_busy;
    } t_dp_status;

endpackage

>>> src/hctg_if.sv
// hctg_in_if / hctg_out_if: valid-ready channels for start items and table entries
// depends on hctg_pkg
`timescale 1ns / 1ps

interface hctg_in_if import hctg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEED_W-1:0] seed;
    logic [ADDR_W-1:0] address_byte;

    modport source (output valid, output seed, output address_byte, input ready);
    modport sink   (input valid, input seed, input address_byte, output ready);
endinterface

interface hctg_out_if import hctg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [CHAN_W-1:0]     channel;
    logic                  last;

    modport source (output valid, output slot_index, output channel, output last, input ready);
    modport sink   (input valid, input slot_index, input channel, input last, output ready);
endinterface

>>> src/hop_channel_table_generator.sv
// hop_channel_table_generator: top level, joins the sequencer and the datapath to the channels
// depends on hctg_pkg, hctg_if, hctg_ctrl, hctg_datapath
`timescale 1ns / 1ps

// one start transfer (seed, address byte) builds a table of NUM_CHANNELS hop channels and sends
// them out in slot order, one output transfer per slot, with last set on the final slot (only
// the first sixteen slots are sent). each draw runs one generator step, one shift, the
// byte-wide remainder-by-41 unit one byte per step, and then forms the channel; the candidate
// of slot k is compared against the k earlier entries at one entry per cycle, and a draw that
// lands too close is thrown away and repeated. an accepted slot is stored and sent; a held-off
// output stalls this store and send. the next start transfer is taken once the last slot has
// been handed to the output register. the table store has no reset: only entries written for
// the current seed are ever compared

module hop_channel_table_generator import hctg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hctg_in_if.sink         i_in,
    hctg_out_if.source      o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: one slot at a time, retries on a close candidate
    hctg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: generator, remainder unit, table, probe compare, output register
    hctg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed         (i_in.seed),
        .i_address_byte (i_in.address_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_slot_index   (o_out.slot_index),
        .o_channel      (o_out.channel),
        .o_last         (o_out.last)
    );

endmodule

>>> src/hctg_datapath.sv
// hctg_datapath: generator state, remainder unit, channel table, probe and output register
// depends on hctg_pkg; driven by hctg_ctrl
`timescale 1ns / 1ps

module hctg_datapath import hctg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SEED_W-1:0]     i_seed,
    input  logic [ADDR_W-1:0]     i_address_byte,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SLOT_OUT_W-1:0] o_slot_index,
    output logic [CHAN_W-1:0]     o_channel,
    output logic                  o_last
);

    localparam t_chan BAND_W_C  = CHAN_W'(BAND_WIDTH);
    localparam t_chan MIN_GAP_C = CHAN_W'(MIN_GAP);
    localparam t_slot SLOT_MAX  = SLOT_W'(NUM_CHANNELS - 1);

    // one byte of restoring remainder by the band width
    function automatic logic [REM_W-1:0] rem_fold(input logic [REM_W-1:0] rem,
                                                  input logic [MOD_DIGIT_W-1:0] digit);
        logic [REM_W:0]   t;
        logic [REM_W-1:0] r;
        r = rem;
        for (int i = MOD_DIGIT_W - 1; i >= 0; i--) begin
            t = {r, digit[i]};
            if (t >= (REM_W+1)'(BAND_WIDTH)) begin
                t = t - (REM_W+1)'(BAND_WIDTH);
            end
            r = t[REM_W-1:0];
        end
        return r;
    endfunction

    // band rotation: low bits of (k<<1 | k>>1&1) plus address
    function automatic logic [1:0] band_of(input t_slot k, input logic [1:0] addr);
        logic [SLOT_W+1:0] kx;
        kx = {2'b00, k};
        return {kx[0], kx[1]} + addr;
    endfunction

    logic [SEED_W-1:0]    r_gen;
    logic [1:0]           r_addr;
    t_slot                r_k;
    t_slot                r_probe;
    logic [SEED_W-1:0]    r_x;
    logic [REM_W-1:0]     r_rem;
    logic [MOD_CNT_W-1:0] r_mod_cnt;
    t_chan                r_cand;
    t_chan                r_table [NUM_CHANNELS];
    t_chan                r_prev;
    logic                 r_out_valid;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    t_chan                r_out_chan;
    logic                 r_out_last;

    t_chan                gap;
    t_chan                n_cand;

    // generator and slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.load_seed) begin
            r_k <= '0;
        end else if (i_cmd.slot_next) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_gen  <= i_seed;
            r_addr <= i_address_byte[1:0];
        end else if (i_cmd.lcg_step) begin
            r_gen <= r_gen * LCG_MUL + LCG_ADD;
        end
    end

    // remainder unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_load) begin
            r_x       <= r_gen >> r_k;
            r_rem     <= '0;
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_x       <= r_x << MOD_DIGIT_W;
            r_rem     <= rem_fold(r_rem, r_x[SEED_W-1 -: MOD_DIGIT_W]);
            r_mod_cnt <= r_mod_cnt + 1'b1;
        end
    end

    assign n_cand = CHAN_W'(band_of(r_k, r_addr)) * BAND_W_C + CHAN_W'(1) + CHAN_W'(r_rem);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cand_load) begin
            r_cand <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cand_load) begin
            r_probe <= '0;
        end else if (i_cmd.probe_inc) begin
            r_probe <= r_probe + 1'b1;
        end
    end

    // channel table
    always_ff @(posedge i_clk) begin
        if (i_cmd.entry_write) begin
            r_table[r_k] <= r_cand;
        end
    end

    // registered read that follows the probe pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.cand_load) begin
            r_prev <= r_table[SLOT_W'(0)];
        end else if (i_cmd.probe_inc) begin
            r_prev <= r_table[r_probe + 1'b1];
        end
    end

    assign gap = (r_cand > r_prev) ? (r_cand - r_prev) : (r_prev - r_cand);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_slot <= SLOT_OUT_W'(r_k);
            r_out_chan <= r_cand;
            r_out_last <= (r_k == SLOT_MAX);
        end
    end

    assign o_status.mod_done   = (r_mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
    assign o_status.slot_zero  = (r_k == '0);
    assign o_status.slot_last  = (r_k == SLOT_MAX);
    assign o_status.slot_out   = (int'(r_k) < MAX_OUT);
    assign o_status.probe_last = (({1'b0, r_probe} + 1'b1) == {1'b0, r_k});
    assign o_status.close      = (gap < MIN_GAP_C);
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_channel    = r_out_chan;
    assign o_last       = r_out_last;

    // a pending entry is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_out_ready))
        else $error("output entry overwritten before transfer");

    // emitted channels stay inside the four bands
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_out_chan >= CHAN_W'(1) &&
                                r_out_chan <= CHAN_W'(4 * BAND_WIDTH)))
        else $error("channel out of range");

    // probing never runs past the entries already filled
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe_inc |-> (({1'b0, r_probe} + 1'b1) < {1'b0, r_k}))
        else $error("probe beyond filled entries");

endmodule

>>> src/hctg_ctrl.sv
// hctg_ctrl: sequencer for draw, remainder, probe and emit of each table slot
// depends on hctg_pkg; commands hctg_datapath
`timescale 1ns / 1ps

module hctg_ctrl import hctg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_LCG   = 7'b000_0010,
        S_SHIFT = 7'b000_0100,
        S_MOD   = 7'b000_1000,
        S_CAND  = 7'b001_0000,
        S_PROBE = 7'b010_0000,
        S_EMIT  = 7'b100_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_seed = 1'b1;
                    n_state         = S_LCG;
                end
            end
            S_LCG: begin
                o_cmd.lcg_step = 1'b1;
                n_state        = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.mod_load = 1'b1;
                n_state        = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_done) begin
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                o_cmd.cand_load = 1'b1;
                n_state         = i_status.slot_zero ? S_EMIT : S_PROBE;
            end
            S_PROBE: begin
                if (i_status.close) begin
                    n_state = S_LCG;
                end else if (i_status.probe_last) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.probe_inc = 1'b1;
                end
            end
            S_EMIT: begin
                if (!(i_status.slot_out && i_status.out_busy)) begin
                    o_cmd.entry_write = 1'b1;
                    o_cmd.out_load    = i_status.slot_out;
                    if (i_status.slot_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.slot_next = 1'b1;
                        n_state         = S_LCG;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a start transfer always begins with a generator step
    a_start_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_LCG))
        else $error("start transfer did not begin a draw");

    // a candidate is formed only after the last remainder step
    a_cand_after_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cand_load |-> ($past(o_cmd.mod_step) && $past(i_status.mod_done)))
        else $error("candidate formed before remainder finished");

endmodule

>>> tb/sv/hctg_table_checker.sv
// hctg_table_checker: watches the start and table-entry channels, predicts each hop table
// and compares every entry field by field; depends on hctg_pkg and hctg_if
`timescale 1ns / 1ps

module hctg_table_checker import hctg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    hctg_in_if   i_in,
    hctg_out_if  i_out,
    output int   o_mismatches,
    output int   o_entries_due,
    output int   o_entries_checked
);

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        t_chan                 channel;
        logic                  last;
    } t_hop_entry;

    t_hop_entry hop_entries_due[$];
    int         mismatch_count = 0;
    int         checked_count  = 0;

    // lcg draw with rejection of channels closer than MIN_GAP to earlier slots
    function automatic void build_hop_table(input logic [SEED_W-1:0] seed,
                                            input logic [ADDR_W-1:0] addr);
        logic [SEED_W-1:0] lcg;
        t_chan             picked [NUM_CHANNELS];
        int unsigned       slot;
        int unsigned       band;
        int unsigned       rem;
        int unsigned       cand;
        int unsigned       prev;
        int unsigned       gap;
        bit                clash;
        t_hop_entry        entry;
        lcg  = seed;
        slot = 0;
        while (slot < NUM_CHANNELS) begin
            band  = (((slot << 1) | ((slot >> 1) & 1)) + addr) & 3;
            lcg   = lcg * LCG_MUL + LCG_ADD;
            rem   = (lcg >> (slot % 32)) % BAND_WIDTH;
            cand  = band * BAND_WIDTH + 1 + rem;
            clash = 1'b0;
            for (int unsigned p = 0; p < slot; p++) begin
                prev = picked[p];
                gap  = (cand > prev) ? cand - prev : prev - cand;
                if (gap < MIN_GAP)
                    clash = 1'b1;
            end
            if (!clash) begin
                picked[slot] = t_chan'(cand);
                if (slot < MAX_OUT) begin
                    entry.slot_index = slot[SLOT_OUT_W-1:0];
                    entry.channel    = t_chan'(cand);
                    entry.last       = (slot + 1 == NUM_CHANNELS);
                    hop_entries_due.push_back(entry);
                end
                slot++;
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_hop_entry want;
        if (i_rst_n) begin
            // entries first: they belong to starts taken at earlier edges
            if (i_out.valid && i_out.ready) begin
                if (hop_entries_due.size() == 0) begin
                    $error("unexpected entry: slot_index %0d channel %0d last %0b",
                           i_out.slot_index, i_out.channel, i_out.last);
                    mismatch_count++;
                end else begin
                    want = hop_entries_due.pop_front();
                    checked_count++;
                    if (i_out.slot_index !== want.slot_index) begin
                        $error("slot_index mismatch: expected %0d, actual %0d",
                               want.slot_index, i_out.slot_index);
                        mismatch_count++;
                    end
                    if (i_out.channel !== want.channel) begin
                        $error("channel mismatch: expected %0d, actual %0d (slot %0d)",
                               want.channel, i_out.channel, want.slot_index);
                        mismatch_count++;
                    end
                    if (i_out.last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b (slot %0d)",
                               want.last, i_out.last, want.slot_index);
                        mismatch_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                build_hop_table(i_in.seed, i_in.address_byte);
        end
        o_mismatches      <= mismatch_count;
        o_entries_checked <= checked_count;
        o_entries_due     <= hop_entries_due.size();
    end

endmodule

>>> tb/sv/testbench.sv
// testbench: clock, reset and stimulus for hop_channel_table_generator, with the verdict
// depends on hctg_pkg, hctg_if, hctg_table_checker and the block itself
`timescale 1ns / 1ps

module testbench import hctg_pkg::*; ();

    // long output hold-off, long enough for the block to fill and stall its input
    localparam int HOLDOFF_CYCLES = 600;

    logic i_clk;
    logic i_rst_n;

    hctg_in_if  in_ch ();
    hctg_out_if out_ch ();

    // idle bursts on both sides while set; cleared for the last stretch of the run
    bit idle_on    = 1'b1;
    // raised by the stimulus, taken and cleared by the output ready process
    bit holdoff_go = 1'b0;
    int starts_sent = 0;

    int mismatches;
    int entries_due;
    int entries_checked;

    hop_channel_table_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    hctg_table_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (in_ch),
        .i_out             (out_ch),
        .o_mismatches      (mismatches),
        .o_entries_due     (entries_due),
        .o_entries_checked (entries_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // generous time bound on the whole run; rejected draws make a table take longer
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: one assignment to ready per edge; random stall bursts, or the long hold-off
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_go) begin
                holdoff_go = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 3);
                out_ch.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // offer one start transfer and wait for it to be taken; valid stays high afterwards
    // so that a following start goes out back to back, unless an idle burst is drawn
    task automatic offer_start(input logic [SEED_W-1:0] seed, input logic [ADDR_W-1:0] addr);
        in_ch.valid        <= 1'b1;
        in_ch.seed         <= seed;
        in_ch.address_byte <= addr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        starts_sent++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every predicted entry has come out; the first edge lets
    // the checker's count catch up with a start taken at the current edge
    task automatic drain_tables();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (entries_due != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.seed         <= '0;
        in_ch.address_byte <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: seed extremes, each band rotation, high address bits that must be
        // ignored, and repeated seeds showing the previous table leaves no trace
        offer_start(32'h0000_0000, 8'h00);
        offer_start(32'hFFFF_FFFF, 8'hFF);
        offer_start(32'h0000_0000, 8'h01);
        offer_start(32'h0000_0000, 8'h02);
        offer_start(32'h0000_0000, 8'h03);
        offer_start(32'h0000_0000, 8'hFC);
        offer_start(32'hFFFF_FFFF, 8'h00);
        offer_start(32'h8000_0000, 8'h80);
        offer_start(32'h0000_0001, 8'h7F);
        offer_start(32'h5555_5555, 8'hAA);
        offer_start(32'hAAAA_AAAA, 8'h55);
        offer_start(32'h1234_5678, 8'h04);
        offer_start(32'h0000_0000, 8'h00);
        offer_start(32'hFFFF_FFFF, 8'hFF);

        // sender pause: nothing new until every entry so far has been seen
        drain_tables();

        // long hold-off on the output while starts keep coming, so the input backs up
        holdoff_go = 1'b1;
        repeat (6) offer_start($urandom(), 8'($urandom_range(0, 255)));
        drain_tables();

        // random seeds and addresses with idle bursts, one more pause midway
        for (int i = 0; i < 240; i++) begin
            offer_start($urandom(), 8'($urandom_range(0, 255)));
            if (i == 120)
                drain_tables();
        end

        // last stretch at full rate on both sides
        idle_on = 1'b0;
        repeat (70) offer_start($urandom(), 8'($urandom_range(0, 255)));

        drain_tables();
        repeat (40) @(posedge i_clk);

        $display("%0d start transfers, %0d table entries compared", starts_sent,
                 entries_checked);
        $display("seed and address extremes, all band rotations, hold-off and drained pauses");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
src/hctg_pkg.sv
src/hctg_if.sv
src/hctg_datapath.sv
src/hctg_ctrl.sv
src/hop_channel_table_generator.sv
tb/sv/hctg_table_checker.sv
tb/sv/testbench.sv
